>>> hw/rtl/mtp_pkg.sv
package mtp_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;

  localparam logic [31:0] SEED_MULT    = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

  // input command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SEED     = 6'b000010,
    ST_TW_PRIME = 6'b000100,
    ST_TW_RUN   = 6'b001000,
    ST_READ     = 6'b010000,
    ST_DELIVER  = 6'b100000
  } mtp_state_e;

  // one step of the regeneration recurrence
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] mid);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    v = mid ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> hw/rtl/mersenne_twister_prng.sv
// MT19937 pseudo-random word generator with multiplicative seeding.
// Input channel (in_valid_i / in_stall_o, cmd_i, seed_value_i): an item is
// taken at a clock edge with valid high and stall low. A seed item forces the
// seed odd and writes the 624-word state, each word the previous times 69069;
// it gives no result and writes one state word per cycle through
// the write port of the state memory. A draw item gives one tempered word on
// the output channel (out_valid_o / out_stall_i, random_word_o).
// A draw from valid state goes through the memory read, then the output
// register once it is free, before out_valid_o rises; the next item can be
// taken once the word is in the output register. When all words are used,
// the draw first regenerates the state, one word per cycle, bound by the
// two read ports and one write port of the state memory. A draw before any
// seed first seeds with 5489.
// One item is worked on at a time; in_stall_o is high until it is finished.
// Reset leaves the generator unseeded; the state memory is not cleared.
// When the receiver stalls, the result holds in the output register; the next
// item is still taken, and a draw waits for the register to free up.
module mersenne_twister_prng
  import mtp_pkg::*;
#(
  parameter int unsigned StateWords   = STATE_WORDS,
  parameter int unsigned MiddleOffset = MIDDLE_OFFSET
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);

  localparam int unsigned AddrW = $clog2(StateWords);

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      wdata;
  logic [AddrW-1:0] raddr_a;
  logic [AddrW-1:0] raddr_b;
  logic [31:0]      rdata_a;
  logic [31:0]      rdata_b;

  logic             word_valid;
  logic [31:0]      word;
  logic             out_free;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_word_q, out_word_d;

  mtp_state_ram #(
    .Depth (StateWords)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  mtp_seq #(
    .StateWords   (StateWords),
    .MiddleOffset (MiddleOffset)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .seed_value_i (seed_value_i),
    .word_valid_o (word_valid),
    .out_free_i   (out_free),
    .word_o       (word),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b)
  );

  // the output register can take a word when empty or being drained now
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    // temper on the way in; load only when the register is free
    if (word_valid && out_free) begin
      out_valid_d = 1'b1;
      out_word_d  = temper(word);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

endmodule

>>> hw/rtl/mtp_state_ram.sv
module mtp_state_ram
  import mtp_pkg::*;
#(
  parameter int unsigned Depth = STATE_WORDS,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [AddrW-1:0]  raddr_a_i,
  input  logic [AddrW-1:0]  raddr_b_i,
  output logic [31:0]       rdata_a_o,
  output logic [31:0]       rdata_b_o
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> hw/rtl/mtp_seq.sv
module mtp_seq
  import mtp_pkg::*;
#(
  parameter int unsigned StateWords   = STATE_WORDS,
  parameter int unsigned MiddleOffset = MIDDLE_OFFSET,
  localparam int unsigned AddrW = $clog2(StateWords),
  localparam int unsigned CntW  = $clog2(StateWords + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [31:0]       seed_value_i,
  output logic              word_valid_o,
  input  logic              out_free_i,
  output logic [31:0]       word_o,
  output logic              we_o,
  output logic [AddrW-1:0]  waddr_o,
  output logic [31:0]       wdata_o,
  output logic [AddrW-1:0]  raddr_a_o,
  output logic [AddrW-1:0]  raddr_b_o,
  input  logic [31:0]       rdata_a_i,
  input  logic [31:0]       rdata_b_i
);

  localparam logic [CntW-1:0] LastIdx = CntW'(StateWords - 1);
  localparam logic [CntW-1:0] Words   = CntW'(StateWords);
  localparam logic [CntW:0]   MidOff  = (CntW + 1)'(MiddleOffset);
  localparam logic [CntW:0]   WrapLim = (CntW + 1)'(StateWords);

  mtp_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            seeded_q, seeded_d;
  logic            pend_q, pend_d;
  logic [31:0]     x_q, x_d;
  logic [31:0]     cur_q, cur_d;

  logic            accept;
  logic [CntW:0]   mid_sum;
  logic [CntW-1:0] mid_idx;
  logic [CntW-1:0] nxt_idx;
  logic [CntW-1:0] wr_idx;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && (state_q == ST_IDLE);
  assign word_valid_o = (state_q == ST_DELIVER);
  assign word_o       = rdata_a_i;

  // neighbor indices of the regeneration step being issued, wrapped
  assign mid_sum = {1'b0, cnt_q} + MidOff;
  assign mid_idx = (mid_sum >= WrapLim) ? CntW'(mid_sum - WrapLim) : CntW'(mid_sum);
  assign nxt_idx = (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;
  assign wr_idx  = cnt_q - 1'b1;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    seeded_d  = seeded_q;
    pend_d    = pend_q;
    x_d       = x_q;
    cur_d     = cur_q;
    we_o      = 1'b0;
    waddr_o   = cnt_q[AddrW-1:0];
    wdata_o   = x_q;
    raddr_a_o = pos_q[AddrW-1:0];
    raddr_b_o = mid_idx[AddrW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (cmd_i == CMD_SEED) begin
            x_d     = seed_value_i | 32'h1;
            pend_d  = 1'b0;
            state_d = ST_SEED;
          end else if (!seeded_q) begin
            x_d     = DEFAULT_SEED | 32'h1;
            pend_d  = 1'b1;
            state_d = ST_SEED;
          end else if (pos_q >= Words) begin
            state_d = ST_TW_PRIME;
          end else begin
            state_d = ST_READ;
          end
        end
      end

      ST_SEED: begin
        // each word is the previous one times the seeding multiplier
        we_o  = 1'b1;
        x_d   = x_q * SEED_MULT;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          pos_d    = Words;
          seeded_d = 1'b1;
          state_d  = pend_q ? ST_TW_PRIME : ST_IDLE;
        end
      end

      ST_TW_PRIME: begin
        raddr_a_o = '0;
        cnt_d     = '0;
        state_d   = ST_TW_RUN;
      end

      ST_TW_RUN: begin
        // issue reads for step cnt, retire step cnt-1
        raddr_a_o = nxt_idx[AddrW-1:0];
        cur_d     = rdata_a_i;
        if (cnt_q != '0) begin
          we_o    = 1'b1;
          waddr_o = wr_idx[AddrW-1:0];
          wdata_o = twist_word(cur_q, rdata_a_i, rdata_b_i);
        end
        if (cnt_q == Words) begin
          pos_d   = '0;
          state_d = ST_READ;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_READ: begin
        state_d = ST_DELIVER;
      end

      ST_DELIVER: begin
        // hold the read address until the output register takes the word
        if (out_free_i) begin
          pos_d   = pos_q + 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      seeded_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      seeded_q <= seeded_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    cur_q <= cur_d;
  end

endmodule

>>> bench/mt_word_check_pkg.sv
package mt_word_check_pkg;
  import mtp_pkg::*;

  // Tracks the generator state and the tempered words that draws still owe.
  class mt_word_scoreboard;
    logic [31:0] words [STATE_WORDS];
    logic [9:0]  next_idx;
    bit          seeded;
    logic [31:0] words_due [$];
    int unsigned mismatches;

    function new();
      next_idx   = '0;
      seeded     = 1'b0;
      mismatches = 0;
    endfunction

    function void load_seed(input logic [31:0] seed);
      logic [31:0] x;
      x = seed | 32'h1;
      words[0] = x;
      for (int unsigned k = 1; k < STATE_WORDS; k++) begin
        x = x * SEED_MULT;
        words[k] = x;
      end
      next_idx = 10'(STATE_WORDS);
      seeded   = 1'b1;
    endfunction

    // In-place rewrite; later words see the already rewritten low ones.
    function void regenerate_state();
      logic [31:0] y;
      logic [31:0] v;
      for (int unsigned k = 0; k < STATE_WORDS; k++) begin
        y = {words[k][31], words[(k + 1) % STATE_WORDS][30:0]};
        v = words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ {1'b0, y[31:1]};
        if (y[0]) begin
          v = v ^ TWIST_MATRIX;
        end
        words[k] = v;
      end
      next_idx = '0;
    endfunction

    function logic [31:0] scramble_word(input logic [31:0] w);
      logic [31:0] t;
      t = w ^ {11'd0, w[31:11]};
      t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
      t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
      t = t ^ {18'd0, t[31:18]};
      return t;
    endfunction

    function void note_command(input logic cmd, input logic [31:0] seed);
      if (cmd == CMD_SEED) begin
        load_seed(seed);
      end else begin
        if (!seeded) begin
          load_seed(DEFAULT_SEED);
        end
        if (next_idx >= STATE_WORDS) begin
          regenerate_state();
        end
        words_due.push_back(scramble_word(words[next_idx]));
        next_idx = next_idx + 10'd1;
      end
    endfunction

    function void check_word(input logic [31:0] got, input longint unsigned stamp);
      logic [31:0] want;
      if (words_due.size() == 0) begin
        $display("%0d ns: random_word_o expected none, actual %h", stamp, got);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        if (got !== want) begin
          $display("%0d ns: random_word_o expected %h, actual %h", stamp, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtp_pkg::*;
  import mt_word_check_pkg::*;

  localparam int unsigned ITEM_TARGET = 1650;
  // Worst single item: seed on first draw plus a regeneration.
  localparam int unsigned DRAIN_CYCLES = 1400;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [31:0] seed_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] random_word_o;

  mt_word_scoreboard sb;
  int unsigned items_sent;
  bit          tx_quiet;
  int unsigned rx_hold;
  int unsigned rx_free;

  mersenne_twister_prng uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .random_word_o(random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Gap length in cycles: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // Drive one item and hold it until taken; the payload stays put while stalled.
  task automatic send_item(input logic cmd, input logic [31:0] seed);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    seed_value_i <= seed;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, seed);
    items_sent++;
  endtask

  task automatic draw_word();
    send_item(CMD_DRAW, $urandom());
  endtask

  task automatic wait_drained();
    while (sb.words_due.size() != 0) @(posedge clk_i);
  endtask

  // Seeds for the random part: corner values now and then, otherwise anything.
  function automatic logic [31:0] pick_seed();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Receiver back-pressure: alternate free stretches with stall bursts.
  initial begin
    out_stall_i = 1'b0;
    rx_hold = 0;
    rx_free = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else if (rx_free != 0) begin
        out_stall_i <= 1'b0;
        rx_free--;
      end else begin
        out_stall_i <= 1'b0;
        rx_free = $urandom_range(40);
        rx_hold = pick_gap();
      end
    end
  end

  // Take a word whenever valid is up and the stall is down.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(random_word_o, $time);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned run_len;
    bit paused;
    sb           = new();
    items_sent   = 0;
    tx_quiet     = 1'b0;
    paused       = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_DRAW;
    seed_value_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Draw with no seed yet: the block must fall back to the default seed.
    draw_word();
    draw_word();
    // Zero seed is forced odd.
    send_item(CMD_SEED, 32'h0000_0000);
    draw_word();
    draw_word();
    send_item(CMD_SEED, 32'hFFFF_FFFF);
    draw_word();
    // Even seed: lowest bit forced high, so this repeats the sequence above.
    send_item(CMD_SEED, 32'hFFFF_FFFE);
    draw_word();
    // Back-to-back seeds: only the second one counts.
    send_item(CMD_SEED, 32'h8000_0000);
    send_item(CMD_SEED, DEFAULT_SEED);
    // Seed field is ignored on a draw.
    send_item(CMD_DRAW, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'h0000_0000);
    send_item(CMD_SEED, 32'h5555_5554);
    draw_word();
    draw_word();
    send_item(CMD_SEED, 32'hAAAA_AAAA);
    draw_word();

    // Random part: a seed, mostly, followed by a run of draws. Force the first
    // run past the end of the state so the words-used-up reload is hit, twice after a seed.
    run_len = 700;
    while (items_sent < ITEM_TARGET) begin
      tx_quiet = ($urandom_range(3) == 0);
      if ($urandom_range(15) != 0) begin
        send_item(CMD_SEED, pick_seed());
      end
      // Stop the run once the item budget is spent.
      for (int unsigned k = 0; k < run_len && items_sent < ITEM_TARGET; k++) begin
        draw_word();
      end
      run_len = ($urandom_range(9) == 0) ? $urandom_range(700, 630) : $urandom_range(40, 1);

      // Once, halfway through: hold off until every owed word is out.
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
    end
    tx_quiet = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.words_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_state_ram.sv
hw/rtl/mtp_seq.sv
hw/rtl/mersenne_twister_prng.sv
bench/mt_word_check_pkg.sv
bench/tb_top.sv
